FILE: src/ufr_pkg.sv
// Shared codes and widths for the delimited serial frame receiver.
`default_nettype none

package ufr_pkg;

  localparam int unsigned ModeW   = 2;
  localparam int unsigned StatusW = 3;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned RdIdxW  = 5;
  localparam int unsigned LenW    = 6;

  localparam logic [ModeW-1:0] ModeByte    = 2'd0;
  localparam logic [ModeW-1:0] ModeRelease = 2'd1;
  localparam logic [ModeW-1:0] ModeRead    = 2'd2;
  localparam logic [ModeW-1:0] ModeUnused  = 2'd3;

  localparam logic [StatusW-1:0] StIgnored = 3'd0;
  localparam logic [StatusW-1:0] StStored  = 3'd1;
  localparam logic [StatusW-1:0] StComplete = 3'd2;
  localparam logic [StatusW-1:0] StDropped = 3'd3;
  localparam logic [StatusW-1:0] StTooLong = 3'd4;
  localparam logic [StatusW-1:0] StDone    = 3'd5;

  localparam logic [CfgIdxW-1:0] RegStartByte = 2'd0;
  localparam logic [CfgIdxW-1:0] RegEndByte   = 2'd1;

  localparam logic [ByteW-1:0] StartByteRst = 8'd2;
  localparam logic [ByteW-1:0] EndByteRst   = 8'd3;
  localparam logic [ByteW-1:0] ErrMax       = 8'd255;

endpackage

`default_nettype wire

FILE: src/ufr_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module ufr_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: src/uart_frame_receiver.sv
// Top level of the start/end delimited serial frame receiver.
//
//  channel | signals                                        | direction
//  --------+------------------------------------------------+----------
//  in      | in_valid_i/in_ready_o, mode, data_byte, rd idx | to block
//  out     | out_valid_o/out_ready_i, six result fields     | from block
//  cfg     | cfg_valid_i/cfg_ready_o, cfg_index_i, cfg_data_i | to block
//
// One transaction per cycle while the output side is not stalled; each result appears the cycle after its input.
// State updates at the input edge; the frame store read data is registered in the RAM.
// A single output stage decouples the sides: input is taken while out is empty or being taken.
// Reset clears control state and the per-entry valid bits (unwritten entries read as zero).
`default_nettype none

module uart_frame_receiver import ufr_pkg::*; #(
  parameter int unsigned BUFFER_BYTES = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [ByteW-1:0]   cfg_data_i,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [ModeW-1:0]   mode_i,
  input  wire logic [ByteW-1:0]   data_byte_i,
  input  wire logic [RdIdxW-1:0]  read_index_i,
  output logic                    out_valid_o,
  input  wire logic               out_ready_i,
  output logic [StatusW-1:0]      status_o,
  output logic                    frame_pending_o,
  output logic [LenW-1:0]         frame_length_o,
  output logic [ByteW-1:0]        read_data_o,
  output logic [ByteW-1:0]        pending_error_count_o,
  output logic [ByteW-1:0]        too_long_error_count_o
);

  localparam int unsigned AddrW = $clog2(BUFFER_BYTES);
  localparam int unsigned IdxW  = $clog2(BUFFER_BYTES + 2);
  localparam logic [IdxW-1:0] IdxBuf = IdxW'(BUFFER_BYTES);
  localparam logic [IdxW-1:0] IdxOne = IdxW'(1);

  logic [ByteW-1:0] start_q, end_q;
  logic [IdxW-1:0]  idx_q, idx_d;
  logic             pend_q, pend_d;
  logic [ByteW-1:0] perr_q, perr_d;
  logic [ByteW-1:0] ovf_q, ovf_d;
  logic [BUFFER_BYTES-1:0] vld_q;
  logic             out_valid_q;
  logic [StatusW-1:0] status_q, status_d;
  logic             rd_hit_q, rd_hit_d;

  logic             accept;
  logic             wr_en;
  logic [AddrW-1:0] waddr;
  logic [AddrW-1:0] raddr;
  logic             rd_range;
  logic             rd_en;
  logic [ByteW-1:0] ram_rdata;

  assign cfg_ready_o = 1'b1;
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign accept      = in_valid_i && in_ready_o;

  assign waddr    = AddrW'(idx_q - IdxOne);
  assign raddr    = AddrW'(read_index_i);
  assign rd_range = 32'(read_index_i) < 32'(BUFFER_BYTES);
  assign rd_en    = accept && (mode_i == ModeRead) && rd_range;

  always_comb begin
    idx_d    = idx_q;
    pend_d   = pend_q;
    perr_d   = perr_q;
    ovf_d    = ovf_q;
    status_d = StIgnored;
    wr_en    = 1'b0;
    rd_hit_d = 1'b0;
    unique case (mode_i)
      ModeByte: begin
        if (pend_q) begin
          status_d = StDropped;
          if (perr_q != ErrMax) perr_d = perr_q + 8'd1;
        end else if (idx_q == '0 && data_byte_i != start_q) begin
          status_d = StIgnored;
        end else begin
          wr_en = (idx_q != '0) && (idx_q <= IdxBuf);
          if (data_byte_i == end_q) begin
            pend_d   = 1'b1;
            status_d = StComplete;
            idx_d    = idx_q + IdxOne;
          end else if (idx_q >= IdxBuf) begin
            status_d = StTooLong;
            idx_d    = IdxOne;
            if (ovf_q != ErrMax) ovf_d = ovf_q + 8'd1;
          end else begin
            status_d = StStored;
            idx_d    = idx_q + IdxOne;
          end
        end
      end
      ModeRelease: begin
        pend_d   = 1'b0;
        idx_d    = '0;
        status_d = StDone;
      end
      ModeRead: begin
        status_d = StDone;
        rd_hit_d = rd_range && vld_q[raddr];
      end
      ModeUnused: begin
        status_d = StIgnored;
      end
      default: begin
        status_d = StIgnored;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_q <= StartByteRst;
      end_q   <= EndByteRst;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == RegStartByte) start_q <= cfg_data_i;
      if (cfg_index_i == RegEndByte) end_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= '0;
      pend_q      <= 1'b0;
      perr_q      <= '0;
      ovf_q       <= '0;
      vld_q       <= '0;
      out_valid_q <= 1'b0;
      status_q    <= StIgnored;
      rd_hit_q    <= 1'b0;
    end else begin
      if (accept) begin
        idx_q    <= idx_d;
        pend_q   <= pend_d;
        perr_q   <= perr_d;
        ovf_q    <= ovf_d;
        status_q <= status_d;
        rd_hit_q <= rd_hit_d;
        if (wr_en) vld_q[waddr] <= 1'b1;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  ufr_ram #(
    .Width(ByteW),
    .Depth(BUFFER_BYTES)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (accept && wr_en),
    .waddr_i(waddr),
    .wdata_i(data_byte_i),
    .re_i   (rd_en),
    .raddr_i(raddr),
    .rdata_o(ram_rdata)
  );

  assign out_valid_o            = out_valid_q;
  assign status_o               = status_q;
  assign frame_pending_o        = pend_q;
  assign frame_length_o         = LenW'(idx_q);
  assign read_data_o            = rd_hit_q ? ram_rdata : '0;
  assign pending_error_count_o  = perr_q;
  assign too_long_error_count_o = ovf_q;

endmodule

`default_nettype wire

FILE: verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for the delimited serial frame receiver: scoreboard, drivers, stimulus.

module tb_top import ufr_pkg::*;;

  localparam int unsigned BufBytes   = 32;
  localparam int unsigned NumPhases  = 6;
  localparam int unsigned PhaseItems = 325;

  localparam logic [CfgIdxW-1:0] RegSpareLo = 2'd2;
  localparam logic [CfgIdxW-1:0] RegSpareHi = 2'd3;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic               pending;
    logic [LenW-1:0]    length;
    logic [ByteW-1:0]   rdata;
    logic [ByteW-1:0]   drop_cnt;
    logic [ByteW-1:0]   long_cnt;
  } frame_result_t;

  class frame_scoreboard;
    logic [ByteW-1:0] start_code;
    logic [ByteW-1:0] end_code;
    int unsigned      rx_index;
    bit               pending;
    logic [ByteW-1:0] store [BufBytes];
    logic [ByteW-1:0] drop_cnt;
    logic [ByteW-1:0] long_cnt;
    frame_result_t    expected_replies [$];
    int unsigned      mismatches;

    function new();
      start_code = StartByteRst;
      end_code   = EndByteRst;
      rx_index   = 0;
      pending    = 1'b0;
      foreach (store[i]) store[i] = '0;
      drop_cnt   = '0;
      long_cnt   = '0;
      mismatches = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [ByteW-1:0] val);
      if (idx == RegStartByte) start_code = val;
      else if (idx == RegEndByte) end_code = val;
    endfunction

    function int unsigned outstanding();
      return expected_replies.size();
    endfunction

    function logic [StatusW-1:0] take_byte(logic [ByteW-1:0] b);
      logic [StatusW-1:0] st;
      st = StStored;
      if (pending) begin
        if (drop_cnt != ErrMax) drop_cnt++;
        return StDropped;
      end
      if (rx_index == 0 && b != start_code) return StIgnored;
      if (rx_index >= 1 && rx_index - 1 < BufBytes) store[rx_index - 1] = b;
      if (b == end_code) begin
        pending = 1'b1;
        st = StComplete;
      end else if (rx_index >= BufBytes) begin
        rx_index = 0;
        if (long_cnt != ErrMax) long_cnt++;
        st = StTooLong;
      end
      rx_index++;
      return st;
    endfunction

    // predicts one transaction and queues its result; returns the predicted status
    function logic [StatusW-1:0] absorb_item(logic [ModeW-1:0] m, logic [ByteW-1:0] b,
                                             logic [RdIdxW-1:0] ri);
      frame_result_t r;
      r = '0;
      r.status = StIgnored;
      case (m)
        ModeByte: r.status = take_byte(b);
        ModeRelease: begin
          pending  = 1'b0;
          rx_index = 0;
          r.status = StDone;
        end
        ModeRead: begin
          if (ri < BufBytes) r.rdata = store[ri];
          r.status = StDone;
        end
        default: ;
      endcase
      r.pending  = pending;
      r.length   = rx_index[LenW-1:0];
      r.drop_cnt = drop_cnt;
      r.long_cnt = long_cnt;
      expected_replies.push_back(r);
      return r.status;
    endfunction

    task report(string what);
      $display("[%0t] frame check error: %s", $realtime, what);
      mismatches++;
    endtask

    task compare_result(frame_result_t got);
      frame_result_t want;
      if (expected_replies.size() == 0) begin
        report("result with no pending transaction");
        return;
      end
      want = expected_replies.pop_front();
      if (got.status !== want.status)
        report($sformatf("status got %0d want %0d", got.status, want.status));
      if (got.pending !== want.pending)
        report($sformatf("frame_pending got %0d want %0d", got.pending, want.pending));
      if (got.length !== want.length)
        report($sformatf("frame_length got %0d want %0d", got.length, want.length));
      if (got.rdata !== want.rdata)
        report($sformatf("read_data got %0d want %0d", got.rdata, want.rdata));
      if (got.drop_cnt !== want.drop_cnt)
        report($sformatf("pending_error_count got %0d want %0d", got.drop_cnt, want.drop_cnt));
      if (got.long_cnt !== want.long_cnt)
        report($sformatf("too_long_error_count got %0d want %0d", got.long_cnt, want.long_cnt));
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [ByteW-1:0]   cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [ModeW-1:0]   mode = ModeByte;
  logic [ByteW-1:0]   data_byte = '0;
  logic [RdIdxW-1:0]  read_index = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [StatusW-1:0] status;
  logic               frame_pending;
  logic [LenW-1:0]    frame_length;
  logic [ByteW-1:0]   read_data;
  logic [ByteW-1:0]   pending_error_count;
  logic [ByteW-1:0]   too_long_error_count;

  frame_scoreboard sb = new();
  int unsigned in_gap_max = 11;
  int unsigned out_stall_max = 11;
  int unsigned counted_items = 0;

  uart_frame_receiver #(.BUFFER_BYTES(BufBytes)) DUT (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .cfg_valid_i            (cfg_valid),
    .cfg_ready_o            (cfg_ready),
    .cfg_index_i            (cfg_index),
    .cfg_data_i             (cfg_data),
    .in_valid_i             (in_valid),
    .in_ready_o             (in_ready),
    .mode_i                 (mode),
    .data_byte_i            (data_byte),
    .read_index_i           (read_index),
    .out_valid_o            (out_valid),
    .out_ready_i            (out_ready),
    .status_o               (status),
    .frame_pending_o        (frame_pending),
    .frame_length_o         (frame_length),
    .read_data_o            (read_data),
    .pending_error_count_o  (pending_error_count),
    .too_long_error_count_o (too_long_error_count)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [ByteW-1:0] pick_byte(logic [ByteW-1:0] avoid);
    logic [ByteW-1:0] b;
    b = ByteW'($urandom_range(0, 255));
    if (b == avoid) b ^= 8'h01;
    return b;
  endfunction

  task automatic send_item(input logic [ModeW-1:0] m, input logic [ByteW-1:0] b,
                           input logic [RdIdxW-1:0] ri);
    int unsigned gap;
    gap = $urandom_range(0, in_gap_max);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid   <= 1'b1;
    mode       <= m;
    data_byte  <= b;
    read_index <= ri;
    do @(posedge clk_i); while (!in_ready);
    void'(sb.absorb_item(m, b, ri));
    counted_items++;
  endtask

  task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [ByteW-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    sb.write_reg(idx, val);
  endtask

  task automatic set_regs(input logic [ByteW-1:0] start_val, input logic [ByteW-1:0] end_val);
    cfg_write($urandom_range(0, 1) ? RegSpareLo : RegSpareHi, ByteW'($urandom_range(0, 255)));
    cfg_write(RegStartByte, start_val);
    cfg_write(RegEndByte, end_val);
    cfg_valid <= 1'b0;
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  task automatic random_sequence();
    int unsigned pick;
    int unsigned len;
    in_gap_max    = ($urandom_range(0, 3) == 0) ? 0 : 11;
    out_stall_max = ($urandom_range(0, 3) == 0) ? 0 : 11;
    pick = $urandom_range(0, 99);
    if (pick < 65) begin
      repeat ($urandom_range(0, 2))
        send_item(ModeByte, pick_byte(sb.start_code), RdIdxW'($urandom));
      send_item(ModeByte, sb.start_code, RdIdxW'($urandom));
      case ($urandom_range(0, 9))
        6:       len = BufBytes - 1;
        7:       len = $urandom_range(BufBytes, BufBytes + 8);
        8:       len = $urandom_range(20, 30);
        9:       len = 0;
        default: len = $urandom_range(0, 6);
      endcase
      repeat (len) send_item(ModeByte, pick_byte(sb.end_code), RdIdxW'($urandom));
      if ($urandom_range(0, 9) != 0) send_item(ModeByte, sb.end_code, RdIdxW'($urandom));
      repeat ($urandom_range(0, 2))
        send_item(ModeByte, ByteW'($urandom), RdIdxW'($urandom));
      repeat ($urandom_range(0, 3))
        send_item(ModeRead, ByteW'($urandom), RdIdxW'($urandom));
      if ($urandom_range(0, 5) != 0)
        send_item(ModeRelease, ByteW'($urandom), RdIdxW'($urandom));
    end else if (pick < 80) begin
      repeat ($urandom_range(1, 6))
        send_item(ModeW'($urandom_range(0, 3)), ByteW'($urandom), RdIdxW'($urandom));
    end else if (pick < 90) begin
      send_item(ModeByte, sb.start_code, RdIdxW'($urandom));
      repeat ($urandom_range(0, 4))
        send_item(ModeByte, pick_byte(sb.end_code), RdIdxW'($urandom));
      send_item(ModeRelease, ByteW'($urandom), RdIdxW'($urandom));
    end else begin
      repeat ($urandom_range(1, 8))
        send_item(ModeRead, ByteW'($urandom), RdIdxW'($urandom));
    end
  endtask

  initial begin
    frame_result_t got;
    int unsigned stall;
    wait (rst_ni === 1'b1);
    forever begin
      stall = $urandom_range(0, out_stall_max);
      if (stall != 0) begin
        out_ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ready <= 1'b1;
      do @(posedge clk_i); while (!out_valid);
      got.status   = status;
      got.pending  = frame_pending;
      got.length   = frame_length;
      got.rdata    = read_data;
      got.drop_cnt = pending_error_count;
      got.long_cnt = too_long_error_count;
      sb.compare_result(got);
    end
  end

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int p = 0; p < NumPhases; p++) begin
      if (p != 0) begin
        drain();
        case (p)
          1:       set_regs(8'h00, 8'hFF);
          2:       set_regs(8'hFF, 8'h00);
          3:       set_regs(8'h7E, 8'h7E);
          default: set_regs(ByteW'($urandom_range(0, 255)), ByteW'($urandom_range(0, 255)));
        endcase
      end
      if (p == 0) begin
        send_item(ModeByte, 8'h55, 5'd0);
        send_item(ModeByte, EndByteRst, 5'd31);
        send_item(ModeUnused, 8'hFF, 5'd31);
        send_item(ModeRelease, 8'h00, 5'd0);
        send_item(ModeRead, 8'h00, 5'd0);
        send_item(ModeRead, 8'hFF, 5'd31);
        send_item(ModeByte, StartByteRst, 5'd0);
        send_item(ModeByte, 8'h00, 5'd0);
        send_item(ModeByte, 8'hFF, 5'd0);
        send_item(ModeByte, StartByteRst, 5'd0);
        send_item(ModeByte, EndByteRst, 5'd0);
        send_item(ModeByte, 8'hAA, 5'd0);
        send_item(ModeByte, StartByteRst, 5'd0);
        for (int i = 0; i < 4; i++) send_item(ModeRead, 8'h00, RdIdxW'(i));
        send_item(ModeRelease, 8'hFF, 5'd31);
        send_item(ModeRead, 8'h00, 5'd1);
        send_item(ModeUnused, 8'h00, 5'd0);
      end
      if (p == 1) begin
        // hold a frame pending long enough to saturate the drop counter
        in_gap_max    = 0;
        out_stall_max = 0;
        send_item(ModeByte, sb.start_code, 5'd0);
        send_item(ModeByte, sb.end_code, 5'd0);
        repeat (260) send_item(ModeByte, ByteW'($urandom), RdIdxW'($urandom));
        send_item(ModeRelease, 8'h00, 5'd0);
      end
      while (counted_items < (p + 1) * PhaseItems) random_sequence();
    end

    drain();
    repeat (4) @(posedge clk_i);
    if (sb.mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #(5_000_000);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
